FILE: rtl/rdc_pkg.sv
`default_nettype none
package rdc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 31;

  localparam int BASE_W  = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int CNT_W   = $clog2(VALUE_WIDTH);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);

  localparam int S_TDATA_W = ((VALUE_WIDTH + BASE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((CHAR_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 2;

  // tuser bit positions on the result side
  localparam int USER_EMPTY = 0;
  localparam int USER_BAD   = 1;

  localparam logic [BASE_W-1:0]  BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX   = BASE_W'(36);
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0]  ASCII_A_OFFSET = ASCII_A - CHAR_W'(10);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d <= DIGIT_NINE) begin
      ch = ASCII_ZERO + CHAR_W'(d);
    end else begin
      ch = ASCII_A_OFFSET + CHAR_W'(d);
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rdc_divider.sv
`default_nettype none
module rdc_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [rdc_pkg::VALUE_WIDTH-1:0]  dividend,
  input  wire logic [rdc_pkg::BASE_W-1:0]       base,
  output rdc_pkg::div_stat_t                    stat,
  output logic      [rdc_pkg::VALUE_WIDTH-1:0]  quotient,
  output logic      [rdc_pkg::DIGIT_W-1:0]      remainder
);
  import rdc_pkg::*;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // at the top while quotient bits shift in at the bottom. base must hold
  // steady while busy.
  logic [VALUE_WIDTH-1:0] quo;
  logic [DIGIT_W-1:0]     rem;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   done;

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic             qbit;

  always_comb begin
    trial = {rem, quo[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, base};
    qbit  = (trial >= {1'b0, base});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(VALUE_WIDTH - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_WIDTH-2:0], qbit};
      rem <= qbit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

FILE: rtl/rdc_digit_store.sv
`default_nettype none
module rdc_digit_store (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [rdc_pkg::ADDR_W-1:0]   waddr,
  input  wire logic [rdc_pkg::DIGIT_W-1:0]  wdata,
  input  wire logic [rdc_pkg::ADDR_W-1:0]   raddr,
  output logic      [rdc_pkg::DIGIT_W-1:0]  rdata
);
  import rdc_pkg::*;

  // Digits, least significant first; contents undefined until written.
  logic [DIGIT_W-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/radix_digit_converter.sv
`default_nettype none
// Channel  Dir  Signals                   Contents (lowest bit first)
// s_*      in   tvalid tready tdata       tdata: value[31:0], base[37:32], zero pad
// m_*      out  tvalid tready tdata tlast tdata: digit_char[6:0], zero pad
//                     tuser               tuser: empty_res[0], bad_base[1]
//
// One item in flight: s_tready is high only while idle. A bad base or a
// value of zero or below yields one flagged result. Otherwise the bit-serial
// divider produces the digits one at a time, then each digit leaves through
// a store read and an output load.
// rst is synchronous; the digit store holds no reset and needs no sweep.
// A stalled m_tready holds the output register and pauses digit emission.
module radix_digit_converter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [rdc_pkg::S_TDATA_W-1:0]   s_tdata,  // value, base
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [rdc_pkg::M_TDATA_W-1:0]   m_tdata,  // digit_char
  output logic                                 m_tlast,
  output logic      [rdc_pkg::M_TUSER_W-1:0]   m_tuser   // empty_res, bad_base
);
  import rdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FLAG = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state;
  logic [DCNT_W-1:0] digit_count;   // digits written so far
  logic [ADDR_W-1:0] ptr;           // next digit to emit, counts down
  logic [BASE_W-1:0] base_reg;
  logic              bad_flag;
  logic              empty_flag;

  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;
  logic [M_TUSER_W-1:0] out_user;
  logic [M_TUSER_W-1:0] flag_user;

  logic [VALUE_WIDTH-1:0] in_value;
  logic [BASE_W-1:0]      in_base;
  logic                   accept;
  logic                   in_bad;
  logic                   in_nonpos;

  div_stat_t              div_stat;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DIGIT_W-1:0]     div_rem;

  logic                   more_digits;
  logic                   out_free;
  logic                   out_load;
  logic [DIGIT_W-1:0]     rd_digit;

  assign in_value  = s_tdata[VALUE_WIDTH-1:0];
  assign in_base   = s_tdata[VALUE_WIDTH +: BASE_W];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_bad    = (in_base < BASE_MIN) || (in_base > BASE_MAX);
  assign in_nonpos = (in_value == '0) || in_value[VALUE_WIDTH-1];

  // Keep dividing while the quotient is nonzero and the store has room.
  assign more_digits = (div_quo != '0) && (digit_count < DCNT_W'(MAX_DIGITS - 1));

  assign div_start = (accept && !in_bad && !in_nonpos) ||
                     ((state == S_DIV) && div_stat.done && more_digits);
  assign div_dividend = (state == S_IDLE) ? in_value : div_quo;

  // base_reg is loaded at accept; the divider only reads it from the next cycle.
  rdc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (base_reg),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rdc_digit_store u_store (
    .clk   (clk),
    .we    ((state == S_DIV) && div_stat.done),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (div_rem),
    .raddr (ptr),
    .rdata (rd_digit)
  );

  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == S_FLAG) || (state == S_EMIT)) && out_free;

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_count <= '0;
      ptr         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            digit_count <= '0;
            state       <= (in_bad || in_nonpos) ? S_FLAG : S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            digit_count <= digit_count + DCNT_W'(1);
            if (!more_digits) begin
              // start from the most significant digit just written
              ptr   <= digit_count[ADDR_W-1:0];
              state <= S_READ;
            end
          end
        end
        S_FLAG: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (ptr == '0) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr - ADDR_W'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item fields captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      base_reg   <= in_base;
      bad_flag   <= in_bad;
      empty_flag <= !in_bad && in_nonpos;
    end
  end

  // Flag bits of a flagged result
  always_comb begin
    flag_user             = '0;
    flag_user[USER_EMPTY] = empty_flag;
    flag_user[USER_BAD]   = bad_flag;
  end

  // Output register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_FLAG) begin
        out_char <= '0;
        out_last <= 1'b1;
        out_user <= flag_user;
      end else begin
        out_char <= digit_to_ascii(rd_digit);
        out_last <= (ptr == '0);
        out_user <= '0;
      end
    end
  end

  assign m_tdata = M_TDATA_W'(out_char);
  assign m_tlast = out_last;
  assign m_tuser = out_user;

  a_flag_path: assert property (@(posedge clk) disable iff (rst)
    accept && (in_bad || in_nonpos) |=> state == S_FLAG)
    else $error("flagged item did not take the flag path");

  a_flag_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != '0) |-> (m_tdata == '0) && m_tlast)
    else $error("flagged result carries a digit or is not last");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("input ready while the divider is busy");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Expected digit items, in emission order, for the values taken by the converter.
class digit_scoreboard;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       empty;
    logic       bad;
  } digit_item_t;

  digit_item_t expected_digits[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  // Expand one accepted value into its digit items, most significant first.
  function void note_value(logic [31:0] value, logic [5:0] base);
    logic [31:0] rest;
    logic [5:0]  low_first[$];
    logic [5:0]  d;
    digit_item_t item;
    if (base < rdc_pkg::BASE_MIN || base > rdc_pkg::BASE_MAX) begin
      item = '{ch: '0, last: 1'b1, empty: 1'b0, bad: 1'b1};
      expected_digits.push_back(item);
    end else if (value == '0 || value[31]) begin
      item = '{ch: '0, last: 1'b1, empty: 1'b1, bad: 1'b0};
      expected_digits.push_back(item);
    end else begin
      rest = value;
      while (rest != '0 && low_first.size() < rdc_pkg::MAX_DIGITS) begin
        low_first.push_back(6'(rest % 32'(base)));
        rest = rest / 32'(base);
      end
      for (int k = low_first.size() - 1; k >= 0; k--) begin
        d = low_first[k];
        item.ch    = (d <= 6'd9) ? rdc_pkg::ASCII_ZERO + 7'(d)
                                 : rdc_pkg::ASCII_A + 7'(d) - 7'd10;
        item.last  = (k == 0);
        item.empty = 1'b0;
        item.bad   = 1'b0;
        expected_digits.push_back(item);
      end
    end
  endfunction

  function void check_digit(logic [6:0] ch, logic last, logic empty, logic bad);
    digit_item_t want;
    if (expected_digits.size() == 0) begin
      $error("unexpected digit item: char=%0d last=%0b empty=%0b bad=%0b",
             ch, last, empty, bad);
      errors++;
      return;
    end
    want = expected_digits.pop_front();
    if (ch !== want.ch) begin
      $error("digit_char: expected %0d, got %0d", want.ch, ch);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, last);
      errors++;
    end
    if (empty !== want.empty) begin
      $error("empty_res: expected %0b, got %0b", want.empty, empty);
      errors++;
    end
    if (bad !== want.bad) begin
      $error("bad_base: expected %0b, got %0b", want.bad, bad);
      errors++;
    end
  endfunction

  function int pending();
    return expected_digits.size();
  endfunction

endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int IDLE_LIMIT   = 10000;
  localparam int HOLD_OFF     = 300;
  localparam int HOLD_AT      = 20;    // digit count at which the hold-off starts
  localparam int RANDOM_ITEMS = 78;
  localparam int DRAIN_CYCLES = 100;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // value[31:0], base[37:32], zero pad
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // digit_char[6:0], zero pad
  logic                 m_tlast;
  logic [M_TUSER_W-1:0] m_tuser;         // empty_res[0], bad_base[1]

  digit_scoreboard digits = new();
  int              digits_seen = 0;
  int              idle_cycles = 0;

  radix_digit_converter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Draw a random per-item gap; a burst flag gives stretches with no gaps.
  function automatic int draw_gap(ref bit burst);
    if ($urandom_range(0, 15) == 0) begin
      burst = ~burst;
    end
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  // Offer one value/base pair and hold it until the converter takes it.
  task automatic send_value(input logic [31:0] value, input logic [5:0] base);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= S_TDATA_W'({base, value});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    digits.note_value(value, base);
  endtask

  // Mostly positive values of random magnitude, so the digit count varies
  // from one to the full width; the rest are 0..40, negative or raw words.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      7: v = $urandom;
      8: v = $urandom_range(0, 40);
      9: v = $urandom | 32'h8000_0000;
      default: begin
        v = $urandom >> $urandom_range(1, 31);
        if (v == '0) begin
          v = 32'd1;
        end
      end
    endcase
    return v;
  endfunction

  // Most bases are legal; one in five covers the whole 6-bit field.
  function automatic logic [5:0] pick_base();
    if ($urandom_range(0, 4) == 0) begin
      return 6'($urandom_range(0, 63));
    end
    return 6'($urandom_range(2, 36));
  endfunction

  // Result side: take digit items with random gaps and one long hold-off
  // while the sender keeps offering, so the converter backs up its input.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = draw_gap(take_burst);
      if (digits_seen == HOLD_AT) begin
        gap = HOLD_OFF;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      digits.check_digit(m_tdata[CHAR_W-1:0], m_tlast,
                         m_tuser[USER_EMPTY], m_tuser[USER_BAD]);
      digits_seen++;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: widest digit strings, smallest values, letter digits,
    // nonpositive values, and bases just outside the legal range.
    send_value(32'h7FFF_FFFF, 6'd2);
    send_value(32'h7FFF_FFFF, 6'd36);
    send_value(32'h7FFF_FFFF, 6'd10);
    send_value(32'd1, 6'd2);
    send_value(32'd1, 6'd36);
    send_value(32'd35, 6'd36);
    send_value(32'd36, 6'd36);
    send_value(32'd10, 6'd16);
    send_value(32'd255, 6'd16);
    send_value(32'd100, 6'd10);
    send_value(32'd7, 6'd8);
    send_value(32'd1000, 6'd3);
    send_value(32'd26, 6'd27);
    send_value(32'd0, 6'd10);
    send_value(32'hFFFF_FFFF, 6'd10);
    send_value(32'h8000_0000, 6'd2);
    send_value(32'd5, 6'd0);
    send_value(32'd5, 6'd1);
    send_value(32'd5, 6'd37);
    send_value(32'd5, 6'd63);
    // bad base wins over a nonpositive value
    send_value(32'hFFFF_FFFB, 6'd63);
    send_value(32'd0, 6'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_value(pick_value(), pick_base());
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every digit, then give stray items time to show up.
    while (digits.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (digits.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
